FILE: src/debounced_digit_matrix_driver_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the debounced digit matrix driver
// Immediate-implication and next-cycle checks, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_DIGIT_MATRIX_DRIVER_CORE_ASSERT_SVH
`define DEBOUNCED_DIGIT_MATRIX_DRIVER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define DDM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ddm check failed (same cycle)");

// Consequent must hold in the cycle after the antecedent
`define DDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ddm check failed (next cycle)");

`endif

FILE: src/ddm_pkg.sv
// ----------------------------------------------------------------------------
// ddm_pkg
// Shared types, register indexes, font and pixel map for the digit driver.
// ----------------------------------------------------------------------------
`default_nettype none

package ddm_pkg;

  localparam int PIXEL_COUNT = 25;
  localparam int PIX_W       = 5;
  localparam int DIGIT_W     = 4;
  localparam int TS_W        = 32;
  localparam int COLOUR_W    = 24;
  localparam int BRIGHT_W    = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int BUTTON_W    = 2;
  localparam int GLYPHS      = 10;
  localparam int FONT_ROWS_N = 5;

  // Largest digit shown
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // floor(v / 100) as (v * 5243) >> 19, exact for v below 2^15
  localparam int              PROD_W      = 15;
  localparam int              RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 13'd5243;
  localparam int              RECIP_SHIFT = 19;
  localparam int              WIDE_W      = PROD_W + RECIP_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_COLOUR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DN_COLOUR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd3;

  // Button codes
  localparam logic [BUTTON_W-1:0] BTN_UP   = 2'd0;
  localparam logic [BUTTON_W-1:0] BTN_DOWN = 2'd1;

  typedef struct packed {
    logic [TS_W-1:0]     debounce_us;
    logic [COLOUR_W-1:0] up_colour;
    logic [COLOUR_W-1:0] down_colour;
    logic [BRIGHT_W-1:0] brightness;
  } cfg_t;

  // One frame request: digit to draw and its raw RGB colour
  typedef struct packed {
    logic [DIGIT_W-1:0]  digit;
    logic [COLOUR_W-1:0] colour;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Physical pixel k shows font cell SERP_MAP[k]
  localparam logic [PIX_W-1:0] SERP_MAP [PIXEL_COUNT] = '{
    5'd24, 5'd23, 5'd22, 5'd21, 5'd20,
    5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
    5'd14, 5'd13, 5'd12, 5'd11, 5'd10,
    5'd5,  5'd6,  5'd7,  5'd8,  5'd9,
    5'd4,  5'd3,  5'd2,  5'd1,  5'd0
  };

  // Row and column of each cell
  localparam logic [2:0] CELL_ROW [PIXEL_COUNT] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4
  };
  localparam logic [2:0] CELL_COL [PIXEL_COUNT] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4
  };

  // Glyph rows, bit 4 is the leftmost column
  localparam logic [4:0] FONT [GLYPHS][FONT_ROWS_N] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h1C, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h1E, 5'h01, 5'h0E, 5'h10, 5'h1F},
    '{5'h1E, 5'h01, 5'h0E, 5'h01, 5'h1E},
    '{5'h12, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h1E},
    '{5'h0E, 5'h10, 5'h1E, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08},
    '{5'h0E, 5'h11, 5'h0E, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h0F, 5'h01, 5'h0E}
  };

  // Is physical pixel pix lit for this digit
  function automatic logic pixel_lit(input logic [DIGIT_W-1:0] digit,
                                     input logic [PIX_W-1:0]   pix);
    logic [PIX_W-1:0] cell_idx;
    logic [2:0]       row;
    logic [2:0]       col;
    logic [4:0]       bits;
    cell_idx = SERP_MAP[pix];
    row      = CELL_ROW[cell_idx];
    col      = CELL_COL[cell_idx];
    if (digit > DIGIT_MAX) begin
      return 1'b0;
    end
    bits = FONT[digit][row];
    return bits[3'd4 - col];
  endfunction

endpackage

`default_nettype wire

FILE: src/ddm_front.sv
// ----------------------------------------------------------------------------
// ddm_front
// Debounces button words, steps the digit and queues frame requests.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_front
  import ddm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cfg_t                cfg_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [TS_W-1:0]     s_axis_tdata,   // timestamp_us
  input  wire logic [BUTTON_W-1:0] s_axis_tuser,   // button
  input  wire qstat_t              qstat_i,
  output logic                     push_o,
  output cmd_t                     cmd_o
);

  logic [TS_W-1:0]    last_ts_q, last_ts_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [TS_W-1:0]    delta;
  logic               accept, pass;

  // Room for a request is all we need to take a word
  assign s_axis_tready = !qstat_i.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Wrapping distance from the last accepted press
  assign delta = s_axis_tdata - last_ts_q;
  assign pass  = delta > cfg_i.debounce_us;

  // Digit step and request
  always_comb begin
    last_ts_d    = last_ts_q;
    digit_d      = digit_q;
    push_o       = 1'b0;
    cmd_o.colour = cfg_i.up_colour;
    if (accept && pass) begin
      last_ts_d = s_axis_tdata;
      case (s_axis_tuser)
        BTN_UP: begin
          digit_d = (digit_q >= DIGIT_MAX) ? '0 : digit_q + 4'd1;
          push_o  = 1'b1;
        end
        BTN_DOWN: begin
          digit_d      = (digit_q == '0 || digit_q > DIGIT_MAX) ? DIGIT_MAX
                                                               : digit_q - 4'd1;
          cmd_o.colour = cfg_i.down_colour;
          push_o       = 1'b1;
        end
        default: begin
        end
      endcase
    end
    cmd_o.digit = digit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ts_q <= '0;
      digit_q   <= '0;
    end else begin
      last_ts_q <= last_ts_d;
      digit_q   <= digit_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/ddm_queue.sv
// ----------------------------------------------------------------------------
// ddm_queue
// Two-entry request queue between the debounce front and the frame back.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_queue
  import ddm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output qstat_t    qstat_o
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign qstat_o.full  = count_q == 2'd2;
  assign qstat_o.empty = count_q == 2'd0;
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign cmd_o         = slot_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/ddm_back.sv
// ----------------------------------------------------------------------------
// ddm_back
// Scales the colour and streams the 25 pixel words of one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ddm_back
  import ddm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [BRIGHT_W-1:0] brightness_i,
  input  wire cmd_t                cmd_i,
  input  wire logic                cmd_valid_i,
  output logic                     pop_o,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [COLOUR_W-1:0]      m_axis_tdata,   // grb_pixel
  output logic                     m_axis_tlast    // last_pixel
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [DIGIT_W-1:0]  digit_q;
  logic [COLOUR_W-1:0] colour_q;
  logic [PROD_W-1:0]   prod_q [3];
  logic [COLOUR_W-1:0] grb_q;
  logic [PIX_W-1:0]    pix_q;
  logic                load;
  logic                last_pix;
  logic [7:0]          scaled [3];

  // floor(prod / 100) with saturation; lane 0 red, 1 green, 2 blue
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [WIDE_W-1:0] wide;
      logic [WIDE_W-RECIP_SHIFT-1:0] quo;
      wide      = WIDE_W'(prod_q[i]) * WIDE_W'(RECIP_MUL);
      quo       = wide[WIDE_W-1:RECIP_SHIFT];
      scaled[i] = (quo > 9'd255) ? 8'hFF : quo[7:0];
    end
  end

  assign last_pix = pix_q == PIX_W'(PIXEL_COUNT - 1);
  assign load     = (state_q == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);
  assign pop_o    = (state_q == ST_IDLE) && cmd_valid_i;

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (cmd_valid_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  state_d = ST_EMIT;
      ST_EMIT: if (load && last_pix) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      digit_q  <= cmd_i.digit;
      colour_q <= cmd_i.colour;
    end
    if (state_q == ST_MUL) begin
      prod_q[0] <= PROD_W'(colour_q[23:16]) * PROD_W'(brightness_i);
      prod_q[1] <= PROD_W'(colour_q[15:8])  * PROD_W'(brightness_i);
      prod_q[2] <= PROD_W'(colour_q[7:0])   * PROD_W'(brightness_i);
    end
    if (state_q == ST_DIV) begin
      grb_q <= {scaled[1], scaled[0], scaled[2]};
    end
    if (load) begin
      m_axis_tdata <= pixel_lit(digit_q, pix_q) ? grb_q : '0;
      m_axis_tlast <= last_pix;
    end
  end

  // Control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pix_q         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV) begin
        pix_q <= '0;
      end else if (load) begin
        pix_q <= pix_q + 5'd1;
      end
      if (load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/debounced_digit_matrix_driver_core.sv
// ----------------------------------------------------------------------------
// debounced_digit_matrix_driver_core
// Debounced up/down digit counter drawn on a 5x5 GRB pixel matrix.
// ----------------------------------------------------------------------------
// Input stream: one word per button event, timestamp in tdata, button in
// tuser. A press is kept when its wrapping distance from the last kept press
// exceeds debounce_us; up and down presses step the digit 0..9 with wrap.
// Output stream: each up or down step yields a frame of 25 GRB words in
// serpentine order, tlast on the 25th. Other buttons only refresh the time.
// The press passes the queue, multiply, divide-by-reciprocal and output
// register before the first pixel is offered; then one word a cycle while
// the receiver is ready.
// A two-deep request queue lets the input keep taking presses while a frame
// streams; tready drops only when two frames are pending.
// A stalled receiver holds the output word; the sequencer waits on it.
// Reset clears the digit and stored time to zero and loads the register
// defaults (debounce 200000 us, red up, blue down, brightness 2 percent).
// Write registers (cfg_we_i/cfg_idx_i/cfg_wdata_i) only while idle; unchecked.
// ----------------------------------------------------------------------------
`default_nettype none

`include "debounced_digit_matrix_driver_core_assert.svh"

module debounced_digit_matrix_driver_core
  import ddm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [TS_W-1:0]       s_axis_tdata,   // [31:0] timestamp_us
  input  wire logic [BUTTON_W-1:0]   s_axis_tuser,   // [1:0] button
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [COLOUR_W-1:0]        m_axis_tdata,   // [23:0] grb_pixel
  output logic                       m_axis_tlast    // last_pixel
);

  cfg_t   cfg_q;
  logic   q_push, q_pop;
  cmd_t   push_cmd, head_cmd;
  qstat_t q_stat;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_us <= 32'd200000;
      cfg_q.up_colour   <= 24'hFF0000;
      cfg_q.down_colour <= 24'h0000FF;
      cfg_q.brightness  <= 7'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEBOUNCE:   cfg_q.debounce_us <= cfg_wdata_i;
        CFG_UP_COLOUR:  cfg_q.up_colour   <= cfg_wdata_i[COLOUR_W-1:0];
        CFG_DN_COLOUR:  cfg_q.down_colour <= cfg_wdata_i[COLOUR_W-1:0];
        CFG_BRIGHTNESS: cfg_q.brightness  <= cfg_wdata_i[BRIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ddm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .qstat_i       (q_stat),
    .push_o        (q_push),
    .cmd_o         (push_cmd)
  );

  ddm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .qstat_o (q_stat)
  );

  ddm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .brightness_i  (cfg_q.brightness),
    .cmd_i         (head_cmd),
    .cmd_valid_i   (!q_stat.empty),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // A request is never offered to a full queue, nor taken from an empty one
  `DDM_ASSERT_SAME(a_push_room, q_push, !q_stat.full)
  `DDM_ASSERT_SAME(a_pop_data, q_pop, !q_stat.empty)
  // Queued digits stay within the font
  `DDM_ASSERT_SAME(a_digit_range, q_push, push_cmd.digit <= DIGIT_MAX)
  // A pushed request is visible to the back end next cycle
  `DDM_ASSERT_NEXT(a_push_seen, q_push, !q_stat.empty)

endmodule

`default_nettype wire
